// ===== design/msla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msla_pkg: shared types, codes and helper functions
// character classes, mnemonic and status codes, operand roles, encoder
// ----------------------------------------------------------------------------
package msla_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int IMM_LONG_BITS  = 26;
  localparam int IMM_SHORT_BITS = 16;

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SP     = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [5:0] OP_LW   = 6'h23;
  localparam logic [5:0] OP_SW   = 6'h2B;
  localparam logic [5:0] OP_BEQ  = 6'h04;
  localparam logic [5:0] OP_J    = 6'h02;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_SLT  = 6'h2A;

  typedef enum logic [3:0] {
    MN_NONE, MN_ADD, MN_SUB, MN_AND, MN_OR, MN_SLT, MN_LW, MN_SW, MN_BEQ, MN_J
  } mnem_t;

  typedef enum logic [2:0] {
    ROLE_NONE, ROLE_RS, ROLE_RT, ROLE_RD, ROLE_IMM, ROLE_MEM
  } role_t;

  typedef enum logic [1:0] {
    ST_OK, ST_TOKENS, ST_MNEM, ST_REG
  } status_t;

  typedef enum logic [1:0] {
    PP_OFFSET, PP_BASE, PP_CLOSED
  } paren_t;

  // classified character as it sits in the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
    logic       digit;
    logic [3:0] dval;
    logic       sep;
    logic       nl;
  } chr_t;

  // register operand scanner state
  typedef struct packed {
    logic       valid;
    logic [2:0] cp;
    logic [5:0] accum;
  } regp_t;

  // immediate scanner state
  typedef struct packed {
    logic [2:0]                 cp;
    logic                       neg;
    logic [IMM_LONG_BITS-1:0]   accum;
  } immp_t;

  // queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // bytes past the token length count as nul, so a nul inside a short
  // token ends the name early
  function automatic mnem_t decode_mnemonic(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2, input logic [2:0] len);
    mnem_t       m;
    logic [23:0] txt;
    m   = MN_NONE;
    txt = {c0, (len >= 3'd2) ? c1 : 8'd0, (len >= 3'd3) ? c2 : 8'd0};
    if (len >= 3'd1 && len <= 3'd3) begin
      unique case (txt)
        "add":           m = MN_ADD;
        "sub":           m = MN_SUB;
        "and":           m = MN_AND;
        "slt":           m = MN_SLT;
        "beq":           m = MN_BEQ;
        {"or", 8'h00}:   m = MN_OR;
        {"lw", 8'h00}:   m = MN_LW;
        {"sw", 8'h00}:   m = MN_SW;
        {"j", 16'h0000}: m = MN_J;
        default:         m = MN_NONE;
      endcase
    end
    return m;
  endfunction

  function automatic role_t role_of(input logic [2:0] t, input mnem_t m);
    role_t r;
    r = ROLE_NONE;
    unique case (m) inside
      MN_ADD, MN_SUB, MN_AND, MN_OR, MN_SLT: begin
        r = (t == 3'd2) ? ROLE_RD : (t == 3'd3) ? ROLE_RS :
            (t == 3'd4) ? ROLE_RT : ROLE_NONE;
      end
      MN_LW, MN_SW: begin
        r = (t == 3'd2) ? ROLE_RT : (t == 3'd3) ? ROLE_MEM : ROLE_NONE;
      end
      MN_BEQ: begin
        r = (t == 3'd2) ? ROLE_RS : (t == 3'd3) ? ROLE_RT :
            (t == 3'd4) ? ROLE_IMM : ROLE_NONE;
      end
      MN_J: begin
        r = (t == 3'd2) ? ROLE_IMM : ROLE_NONE;
      end
      default: r = ROLE_NONE;
    endcase
    return r;
  endfunction

  // one byte of a register operand: '$', one or two digits, optional comma
  function automatic regp_t reg_char(input regp_t s, input chr_t c);
    regp_t r;
    logic [5:0] acc10;
    r = s;
    acc10 = (s.accum << 3) + (s.accum << 1) + {2'b00, c.dval};
    if (s.valid) begin
      case (s.cp)
        3'd0: begin
          if (c.ch != CH_DOLLAR) r.valid = 1'b0;
          r.cp = 3'd1;
        end
        3'd1: begin
          if (c.digit) begin
            r.accum = {2'b00, c.dval};
            r.cp    = 3'd2;
          end else begin
            r.valid = 1'b0;
          end
        end
        3'd2: begin
          if (c.digit) begin
            if (s.accum < 6'd1 || s.accum > 6'd3) begin
              r.valid = 1'b0;
            end else begin
              r.accum = acc10;
              if (acc10 > 6'd31) r.valid = 1'b0;
              r.cp = 3'd3;
            end
          end else if (c.ch == CH_COMMA) begin
            r.cp = 3'd4;
          end else begin
            r.valid = 1'b0;
          end
        end
        3'd3: begin
          if (c.ch == CH_COMMA) r.cp = 3'd4;
          else r.valid = 1'b0;
        end
        default: r.valid = 1'b0;
      endcase
    end
    return r;
  endfunction

  // one byte of a decimal immediate: optional sign, digits until a non-digit
  function automatic immp_t imm_char(input immp_t s, input chr_t c);
    immp_t r;
    r = s;
    if (s.cp == 3'd0) begin
      if (c.ch == CH_MINUS) begin
        r.neg = 1'b1;
        r.cp  = 3'd1;
      end else if (c.ch == CH_PLUS) begin
        r.cp = 3'd1;
      end else if (c.digit) begin
        r.accum = {{(IMM_LONG_BITS-4){1'b0}}, c.dval};
        r.cp    = 3'd1;
      end else begin
        r.cp = 3'd2;
      end
    end else if (s.cp == 3'd1) begin
      if (c.digit) begin
        r.accum = (s.accum << 3) + (s.accum << 1) + {{(IMM_LONG_BITS-4){1'b0}}, c.dval};
      end else begin
        r.cp = 3'd2;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] encode(input mnem_t m, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [4:0] rd,
                                         input logic [IMM_LONG_BITS-1:0] acc,
                                         input logic neg);
    logic [IMM_LONG_BITS-1:0]  imm;
    logic [IMM_SHORT_BITS-1:0] imm16;
    logic [31:0]               w;
    imm   = neg ? ({IMM_LONG_BITS{1'b0}} - acc) : acc;
    imm16 = imm[IMM_SHORT_BITS-1:0];
    unique case (m)
      MN_ADD:  w = {6'd0, rs, rt, rd, 5'd0, FN_ADD};
      MN_SUB:  w = {6'd0, rs, rt, rd, 5'd0, FN_SUB};
      MN_AND:  w = {6'd0, rs, rt, rd, 5'd0, FN_AND};
      MN_OR:   w = {6'd0, rs, rt, rd, 5'd0, FN_OR};
      MN_SLT:  w = {6'd0, rs, rt, rd, 5'd0, FN_SLT};
      MN_LW:   w = {OP_LW, rs, rt, imm16};
      MN_SW:   w = {OP_SW, rs, rt, imm16};
      MN_BEQ:  w = {OP_BEQ, rs, rt, imm16};
      default: w = {OP_J, imm};
    endcase
    return w;
  endfunction

endpackage

// ===== design/msla_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msla_front: input side
// takes text bytes and classifies them for the parser queue
// ----------------------------------------------------------------------------
module msla_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_char,
  input  logic            s_eof,
  input  msla_pkg::qstat_t qstat,
  output logic            push,
  output msla_pkg::chr_t  push_data
);
  import msla_pkg::*;

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && !qstat.full;

  always_comb begin
    push_data.ch    = s_char;
    push_data.eof   = s_eof;
    push_data.digit = (s_char >= CH_ZERO) && (s_char <= CH_NINE);
    push_data.dval  = 4'(s_char - CH_ZERO);
    push_data.sep   = (s_char == CH_SP);
    push_data.nl    = (s_char == CH_NL);
  end

endmodule

// ===== design/msla_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msla_queue: classified character queue
// short fifo that decouples the front from the parser
// ----------------------------------------------------------------------------
module msla_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  msla_pkg::chr_t   push_data,
  input  logic             pop,
  output msla_pkg::chr_t   pop_data,
  output msla_pkg::qstat_t qstat
);
  import msla_pkg::*;

  chr_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign qstat.full  = (count == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign pop_data    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QAW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QAW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/msla_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msla_back: line parser and encoder
// tokenizes, decodes operands, and registers one word per closed line
// ----------------------------------------------------------------------------
module msla_back (
  input  logic                 clk,
  input  logic                 rst,
  input  msla_pkg::qstat_t     qstat,
  input  msla_pkg::chr_t       q_data,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_word,
  output msla_pkg::status_t    m_status,
  output logic                 m_write_ok
);
  import msla_pkg::*;

  logic [2:0]               token_index, token_index_next;
  logic                     in_token, in_token_next;
  logic [2:0]               char_position, char_position_next;
  mnem_t                    mnemonic_match, mnemonic_match_next;
  logic [7:0]               mnem0, mnem0_next, mnem1, mnem1_next, mnem2, mnem2_next;
  logic [5:0]               reg_accum, reg_accum_next;
  logic                     reg_valid, reg_valid_next;
  logic [4:0]               source_reg, source_reg_next;
  logic [4:0]               target_reg, target_reg_next;
  logic [4:0]               dest_reg, dest_reg_next;
  logic [IMM_LONG_BITS-1:0] imm_accum, imm_accum_next;
  logic                     imm_negative, imm_negative_next;
  paren_t                   paren_phase, paren_phase_next;
  status_t                  pending_status, pending_status_next;
  logic                     sticky_error, sticky_error_next;

  logic                     res_valid;
  logic [31:0]              res_word;
  status_t                  res_status;
  logic                     res_ok;

  assign pop = !qstat.empty && (!m_tvalid || m_tready);

  always_comb begin
    regp_t      rp;
    immp_t      ip;
    role_t      role;
    logic [2:0] need;
    status_t    st;
    chr_t       c;

    c = q_data;
    token_index_next    = token_index;
    in_token_next       = in_token;
    char_position_next  = char_position;
    mnemonic_match_next = mnemonic_match;
    mnem0_next          = mnem0;
    mnem1_next          = mnem1;
    mnem2_next          = mnem2;
    reg_accum_next      = reg_accum;
    reg_valid_next      = reg_valid;
    source_reg_next     = source_reg;
    target_reg_next     = target_reg;
    dest_reg_next       = dest_reg;
    imm_accum_next      = imm_accum;
    imm_negative_next   = imm_negative;
    paren_phase_next    = paren_phase;
    pending_status_next = pending_status;
    sticky_error_next   = sticky_error;
    res_valid  = 1'b0;
    res_word   = '0;
    res_status = ST_OK;
    res_ok     = 1'b0;
    rp   = '0;
    ip   = '0;
    role = ROLE_NONE;
    need = 3'd0;
    st   = ST_OK;

    if (pop) begin
      // token byte
      if (!c.sep && !c.nl) begin
        if (!in_token_next) begin
          if (token_index_next != 3'd7) token_index_next = token_index_next + 3'd1;
          in_token_next      = 1'b1;
          char_position_next = 3'd0;
          reg_accum_next     = 6'd0;
          reg_valid_next     = 1'b1;
          paren_phase_next   = PP_OFFSET;
        end
        if (token_index_next == 3'd1) begin
          // mnemonic: keep the first three bytes, count up to seven
          case (char_position_next)
            3'd0:    mnem0_next = c.ch;
            3'd1:    mnem1_next = c.ch;
            3'd2:    mnem2_next = c.ch;
            default: ;
          endcase
          if (char_position_next != 3'd7) char_position_next = char_position_next + 3'd1;
        end else begin
          role = role_of(token_index_next, mnemonic_match_next);
          rp.valid = reg_valid_next;
          rp.cp    = char_position_next;
          rp.accum = reg_accum_next;
          ip.cp    = char_position_next;
          ip.neg   = imm_negative_next;
          ip.accum = imm_accum_next;
          unique case (role)
            ROLE_RS, ROLE_RT, ROLE_RD: begin
              rp = reg_char(rp, c);
              reg_valid_next     = rp.valid;
              char_position_next = rp.cp;
              reg_accum_next     = rp.accum;
            end
            ROLE_IMM: begin
              ip = imm_char(ip, c);
              char_position_next = ip.cp;
              imm_negative_next  = ip.neg;
              imm_accum_next     = ip.accum;
            end
            ROLE_MEM: begin
              case (paren_phase_next)
                PP_OFFSET: begin
                  if (c.ch == CH_LPAREN) begin
                    paren_phase_next   = PP_BASE;
                    char_position_next = 3'd0;
                    reg_accum_next     = 6'd0;
                    reg_valid_next     = 1'b1;
                  end else begin
                    ip = imm_char(ip, c);
                    char_position_next = ip.cp;
                    imm_negative_next  = ip.neg;
                    imm_accum_next     = ip.accum;
                  end
                end
                PP_BASE: begin
                  if (c.ch == CH_RPAREN) begin
                    if (reg_valid_next && char_position_next >= 3'd2) begin
                      source_reg_next = reg_accum_next[4:0];
                    end else begin
                      pending_status_next = ST_REG;
                    end
                    paren_phase_next = PP_CLOSED;
                  end else begin
                    rp = reg_char(rp, c);
                    reg_valid_next     = rp.valid;
                    char_position_next = rp.cp;
                    reg_accum_next     = rp.accum;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end

      // token end
      if ((c.sep || c.nl || c.eof) && in_token_next) begin
        in_token_next = 1'b0;
        if (token_index_next == 3'd1) begin
          mnemonic_match_next = decode_mnemonic(mnem0_next, mnem1_next, mnem2_next,
                                                char_position_next);
        end else begin
          role = role_of(token_index_next, mnemonic_match_next);
          unique case (role)
            ROLE_RS, ROLE_RT, ROLE_RD: begin
              if (reg_valid_next && char_position_next >= 3'd2) begin
                case (role)
                  ROLE_RS: source_reg_next = reg_accum_next[4:0];
                  ROLE_RT: target_reg_next = reg_accum_next[4:0];
                  default: dest_reg_next   = reg_accum_next[4:0];
                endcase
              end else begin
                pending_status_next = ST_REG;
              end
            end
            ROLE_MEM: begin
              if (paren_phase_next != PP_CLOSED) pending_status_next = ST_REG;
            end
            default: ;
          endcase
        end
      end

      // line close
      if (c.nl || c.eof) begin
        unique case (mnemonic_match_next) inside
          MN_NONE, MN_ADD, MN_SUB, MN_AND, MN_OR, MN_SLT: need = 3'd4;
          MN_J:                                           need = 3'd1;
          default:                                        need = 3'd3;
        endcase
        if (token_index_next > 3'd4)            st = ST_TOKENS;
        else if (mnemonic_match_next == MN_NONE) st = ST_MNEM;
        else if (token_index_next < need)        st = ST_REG;
        else                                     st = pending_status_next;
        if (st == ST_OK) begin
          res_word = encode(mnemonic_match_next, source_reg_next, target_reg_next,
                            dest_reg_next, imm_accum_next, imm_negative_next);
        end else begin
          sticky_error_next = 1'b1;
        end
        res_valid  = 1'b1;
        res_status = st;
        res_ok     = (st == ST_OK) && !sticky_error_next;

        token_index_next    = 3'd0;
        in_token_next       = 1'b0;
        char_position_next  = 3'd0;
        mnemonic_match_next = MN_NONE;
        mnem0_next          = 8'd0;
        mnem1_next          = 8'd0;
        mnem2_next          = 8'd0;
        reg_accum_next      = 6'd0;
        reg_valid_next      = 1'b0;
        source_reg_next     = 5'd0;
        target_reg_next     = 5'd0;
        dest_reg_next       = 5'd0;
        imm_accum_next      = '0;
        imm_negative_next   = 1'b0;
        paren_phase_next    = PP_OFFSET;
        pending_status_next = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_index    <= 3'd0;
      in_token       <= 1'b0;
      char_position  <= 3'd0;
      mnemonic_match <= MN_NONE;
      mnem0          <= 8'd0;
      mnem1          <= 8'd0;
      mnem2          <= 8'd0;
      reg_accum      <= 6'd0;
      reg_valid      <= 1'b0;
      source_reg     <= 5'd0;
      target_reg     <= 5'd0;
      dest_reg       <= 5'd0;
      imm_accum      <= '0;
      imm_negative   <= 1'b0;
      paren_phase    <= PP_OFFSET;
      pending_status <= ST_OK;
      sticky_error   <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      token_index    <= token_index_next;
      in_token       <= in_token_next;
      char_position  <= char_position_next;
      mnemonic_match <= mnemonic_match_next;
      mnem0          <= mnem0_next;
      mnem1          <= mnem1_next;
      mnem2          <= mnem2_next;
      reg_accum      <= reg_accum_next;
      reg_valid      <= reg_valid_next;
      source_reg     <= source_reg_next;
      target_reg     <= target_reg_next;
      dest_reg       <= dest_reg_next;
      imm_accum      <= imm_accum_next;
      imm_negative   <= imm_negative_next;
      paren_phase    <= paren_phase_next;
      pending_status <= pending_status_next;
      sticky_error   <= sticky_error_next;
      if (pop && res_valid) m_tvalid <= 1'b1;
      else if (m_tready)    m_tvalid <= 1'b0;
    end
  end

  // output payload, loaded only when a line closes
  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      m_word     <= res_word;
      m_status   <= res_status;
      m_write_ok <= res_ok;
    end
  end

endmodule

// ===== design/mips_subset_line_assembler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_line_assembler_unit: line assembler for a small mips subset
// turns assembly text, one byte per transaction, into one word per line
// ----------------------------------------------------------------------------
// path: the byte that closes a line is stored in the queue, then the parser
//   steps it from the queue into the output register that holds the word
// throughput: one byte per cycle, set by the parser step; a word
//   held by the sink stalls the parser, the two-entry queue then fills
// reset: synchronous, clears parser, queue, output valid and the error flag;
//   no clearing pass, bytes are taken in the first cycle after reset
// ----------------------------------------------------------------------------
module mips_subset_line_assembler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] instr_word
  output logic [2:0]  m_axis_tuser    // [1:0] line_status, [2] write_ok
);
  import msla_pkg::*;

  qstat_t  qstat;
  logic    push;
  chr_t    push_data;
  logic    pop;
  chr_t    pop_data;
  status_t status;
  logic    write_ok;

  // front: classify each byte and hand it to the queue
  msla_front u_front (
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_char    (s_axis_tdata),
    .s_eof     (s_axis_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // two-entry queue so input and output can stall independently
  msla_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // back: tokenizer, operand scanners, encoder and output register
  msla_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .q_data     (pop_data),
    .pop        (pop),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_word     (m_axis_tdata),
    .m_status   (status),
    .m_write_ok (write_ok)
  );

  // status and the write flag describe the word, so they ride in tuser
  assign m_axis_tuser = {write_ok, status};

endmodule

// ===== tb/assembler_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembler_checker: scoreboard for the mips subset line assembler
// follows every byte transaction into the block, assembles each line on its
// own and compares word, status and write flag of every output transaction
// ----------------------------------------------------------------------------
module assembler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // end_of_file
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] instr_word
  input  logic [2:0]  m_axis_tuser,   // [1:0] line_status, [2] write_ok
  output int          mismatch_count,
  output int          words_outstanding
);
  import msla_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    status_t     status;
    logic        write_ok;
  } line_result_t;

  line_result_t expected_words[$];

  // per-line parse state
  logic [2:0]               tok_count;
  logic                     in_tok;
  logic [2:0]               scan_pos;
  mnem_t                    mnem;
  logic [0:2][7:0]          mnem_text;
  logic [5:0]               reg_acc;
  logic                     reg_ok;
  logic [4:0]               rs_field;
  logic [4:0]               rt_field;
  logic [4:0]               rd_field;
  logic [IMM_LONG_BITS-1:0] imm_mag;
  logic                     imm_neg;
  paren_t                   paren;
  status_t                  line_err;
  // survives line ends, cleared only by reset
  logic                     error_seen;

  function automatic role_t operand_role(input logic [2:0] tok, input mnem_t m);
    role_t r;
    r = ROLE_NONE;
    case (m)
      MN_ADD, MN_SUB, MN_AND, MN_OR, MN_SLT: begin
        if (tok == 3'd2) r = ROLE_RD;
        else if (tok == 3'd3) r = ROLE_RS;
        else if (tok == 3'd4) r = ROLE_RT;
      end
      MN_LW, MN_SW: begin
        if (tok == 3'd2) r = ROLE_RT;
        else if (tok == 3'd3) r = ROLE_MEM;
      end
      MN_BEQ: begin
        if (tok == 3'd2) r = ROLE_RS;
        else if (tok == 3'd3) r = ROLE_RT;
        else if (tok == 3'd4) r = ROLE_IMM;
      end
      MN_J: begin
        if (tok == 3'd2) r = ROLE_IMM;
      end
      default: r = ROLE_NONE;
    endcase
    return r;
  endfunction

  // bytes past the token length stay zero, so a nul inside a short
  // mnemonic still matches the shorter name
  function automatic mnem_t lookup_mnemonic();
    mnem_t m;
    m = MN_NONE;
    if (scan_pos >= 3'd1 && scan_pos <= 3'd3) begin
      case (mnem_text)
        "add":           m = MN_ADD;
        "sub":           m = MN_SUB;
        "and":           m = MN_AND;
        "slt":           m = MN_SLT;
        "beq":           m = MN_BEQ;
        {"or", 8'h00}:   m = MN_OR;
        {"lw", 8'h00}:   m = MN_LW;
        {"sw", 8'h00}:   m = MN_SW;
        {"j", 16'h0000}: m = MN_J;
        default:         m = MN_NONE;
      endcase
    end
    return m;
  endfunction

  function automatic logic [31:0] machine_word();
    logic [IMM_LONG_BITS-1:0] imm;
    logic [31:0]              w;
    imm = imm_neg ? -imm_mag : imm_mag;
    w = {6'd0, rs_field, rt_field, rd_field, 5'd0, 6'd0};
    case (mnem)
      MN_ADD: w[5:0] = FN_ADD;
      MN_SUB: w[5:0] = FN_SUB;
      MN_AND: w[5:0] = FN_AND;
      MN_OR:  w[5:0] = FN_OR;
      MN_SLT: w[5:0] = FN_SLT;
      MN_LW:  w = {OP_LW, rs_field, rt_field, imm[IMM_SHORT_BITS-1:0]};
      MN_SW:  w = {OP_SW, rs_field, rt_field, imm[IMM_SHORT_BITS-1:0]};
      MN_BEQ: w = {OP_BEQ, rs_field, rt_field, imm[IMM_SHORT_BITS-1:0]};
      default: w = {OP_J, imm};
    endcase
    return w;
  endfunction

  task automatic clear_line();
    tok_count = 3'd0;
    in_tok    = 1'b0;
    scan_pos  = 3'd0;
    mnem      = MN_NONE;
    mnem_text = '0;
    reg_acc   = 6'd0;
    reg_ok    = 1'b0;
    rs_field  = 5'd0;
    rt_field  = 5'd0;
    rd_field  = 5'd0;
    imm_mag   = '0;
    imm_neg   = 1'b0;
    paren     = PP_OFFSET;
    line_err  = ST_OK;
  endtask

  // '$', one or two digits, one optional comma
  task automatic scan_reg(input logic [7:0] c);
    logic is_digit;
    int   v;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (reg_ok) begin
      case (scan_pos)
        3'd0: begin
          if (c != CH_DOLLAR) reg_ok = 1'b0;
          scan_pos = 3'd1;
        end
        3'd1: begin
          if (is_digit) begin
            reg_acc  = {2'b00, c[3:0]};
            scan_pos = 3'd2;
          end else begin
            reg_ok = 1'b0;
          end
        end
        3'd2: begin
          if (is_digit) begin
            if (reg_acc < 6'd1 || reg_acc > 6'd3) begin
              reg_ok = 1'b0;
            end else begin
              v        = reg_acc * 10 + c[3:0];
              reg_acc  = v[5:0];
              if (reg_acc > 6'd31) reg_ok = 1'b0;
              scan_pos = 3'd3;
            end
          end else if (c == CH_COMMA) begin
            scan_pos = 3'd4;
          end else begin
            reg_ok = 1'b0;
          end
        end
        3'd3: begin
          if (c == CH_COMMA) scan_pos = 3'd4;
          else reg_ok = 1'b0;
        end
        default: reg_ok = 1'b0;
      endcase
    end
  endtask

  // atoi style: sign, then digits up to the first other byte
  task automatic scan_imm(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (scan_pos == 3'd0) begin
      if (c == CH_MINUS) begin
        imm_neg  = 1'b1;
        scan_pos = 3'd1;
      end else if (c == CH_PLUS) begin
        scan_pos = 3'd1;
      end else if (is_digit) begin
        imm_mag  = {{(IMM_LONG_BITS-4){1'b0}}, c[3:0]};
        scan_pos = 3'd1;
      end else begin
        scan_pos = 3'd2;
      end
    end else if (scan_pos == 3'd1) begin
      if (is_digit) imm_mag = IMM_LONG_BITS'(imm_mag * 10 + c[3:0]);
      else scan_pos = 3'd2;
    end
  endtask

  task automatic store_reg(input role_t role);
    if (reg_ok && scan_pos >= 3'd2) begin
      case (role)
        ROLE_RS: rs_field = reg_acc[4:0];
        ROLE_RT: rt_field = reg_acc[4:0];
        default: rd_field = reg_acc[4:0];
      endcase
    end else begin
      line_err = ST_REG;
    end
  endtask

  task automatic token_char(input logic [7:0] c);
    role_t role;
    role = operand_role(tok_count, mnem);
    if (tok_count == 3'd1) begin
      if (scan_pos < 3'd3) mnem_text[scan_pos[1:0]] = c;
      if (scan_pos != 3'd7) scan_pos++;
    end else if (role == ROLE_RS || role == ROLE_RT || role == ROLE_RD) begin
      scan_reg(c);
    end else if (role == ROLE_IMM) begin
      scan_imm(c);
    end else if (role == ROLE_MEM) begin
      if (paren == PP_OFFSET) begin
        if (c == CH_LPAREN) begin
          paren    = PP_BASE;
          scan_pos = 3'd0;
          reg_acc  = 6'd0;
          reg_ok   = 1'b1;
        end else begin
          scan_imm(c);
        end
      end else if (paren == PP_BASE) begin
        if (c == CH_RPAREN) begin
          store_reg(ROLE_RS);
          paren = PP_CLOSED;
        end else begin
          scan_reg(c);
        end
      end
    end
  endtask

  task automatic token_done();
    role_t role;
    in_tok = 1'b0;
    role   = operand_role(tok_count, mnem);
    if (tok_count == 3'd1) mnem = lookup_mnemonic();
    else if (role == ROLE_RS || role == ROLE_RT || role == ROLE_RD) store_reg(role);
    else if (role == ROLE_MEM && paren != PP_CLOSED) line_err = ST_REG;
  endtask

  task automatic close_line();
    line_result_t r;
    status_t      st;
    logic [2:0]   need;
    if (mnem == MN_J) need = 3'd1;
    else if (mnem == MN_LW || mnem == MN_SW || mnem == MN_BEQ) need = 3'd3;
    else need = 3'd4;
    if (tok_count > 3'd4) st = ST_TOKENS;
    else if (mnem == MN_NONE) st = ST_MNEM;
    else if (tok_count < need) st = ST_REG;
    else st = line_err;
    r.word = 32'd0;
    if (st == ST_OK) r.word = machine_word();
    else error_seen = 1'b1;
    r.status   = st;
    r.write_ok = (st == ST_OK) && !error_seen;
    expected_words.push_back(r);
    clear_line();
  endtask

  task automatic assemble_char(input logic [7:0] c, input logic eof);
    logic blank;
    logic nl;
    blank = (c == CH_SP);
    nl    = (c == CH_NL);
    if (!blank && !nl) begin
      if (!in_tok) begin
        if (tok_count != 3'd7) tok_count++;
        in_tok   = 1'b1;
        scan_pos = 3'd0;
        reg_acc  = 6'd0;
        reg_ok   = 1'b1;
        paren    = PP_OFFSET;
      end
      token_char(c);
    end
    if ((blank || nl || eof) && in_tok) token_done();
    if (nl || eof) close_line();
  endtask

  // output side first: a word never comes from the byte taken at the same edge
  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      clear_line();
      error_seen = 1'b0;
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("word %h with no line waiting", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata !== want.word) begin
            $error("instr_word: expected %h, actual %h", want.word, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser[1:0] !== want.status) begin
            $error("line_status: expected %0d, actual %0d", want.status, m_axis_tuser[1:0]);
            mismatch_count++;
          end
          if (m_axis_tuser[2] !== want.write_ok) begin
            $error("write_ok: expected %0b, actual %0b", want.write_ok, m_axis_tuser[2]);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) assemble_char(s_axis_tdata, s_axis_tlast);
    end
    words_outstanding = expected_words.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the mips subset line assembler
// feeds directed lines, then mostly well-formed random lines with broken
// operands and raw byte noise mixed in; both stream sides stall at random
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_BYTES = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_in
  logic        s_axis_tlast = 1'b0;   // end_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [31:0] instr_word
  logic [2:0]  m_axis_tuser;          // [1:0] line_status, [2] write_ok

  int mismatch_count;
  int words_outstanding;
  int bytes_sent = 0;
  int cycle_count = 0;
  int send_calm = 0;
  int recv_calm = 0;

  logic [7:0] line_bytes[$];

  string mnem_names[9] = '{"add", "sub", "and", "or", "slt", "lw", "sw", "beq", "j"};
  string bad_names[10] = '{"ad", "addx", "mul", "jr", "lwz", "s", "beqq", "nop", "J", "Or"};

  mips_subset_line_assembler_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  assembler_checker line_check (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tlast      (s_axis_tlast),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .mismatch_count    (mismatch_count),
    .words_outstanding (words_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // gap before the next transaction, with occasional runs of back-to-back ones
  task automatic draw_pause(inout int calm, output int cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      calm   = $urandom_range(20, 80);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 12);
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eof);
    int pause;
    draw_pause(send_calm, pause);
    if (pause > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // eof rides on the last byte of the text when asked
  task automatic send_text(input string s, input logic eof);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eof && (i == s.len() - 1));
  endtask

  function automatic string reg_token();
    int n;
    n = $urandom_range(0, 31);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 6))
        0: return $sformatf("$%0d", $urandom_range(32, 99));
        1: return $sformatf("$0%0d", $urandom_range(0, 9));
        2: return "$";
        3: return $sformatf("r%0d", n);
        4: return $sformatf("$%0d,x", n);
        5: return $sformatf("$%0d,,", n);
        default: return $sformatf("$%0d%0d", n, $urandom_range(0, 9));
      endcase
    end
    if ($urandom_range(0, 1) == 1) return $sformatf("$%0d,", n);
    return $sformatf("$%0d", n);
  endfunction

  function automatic string imm_token();
    string sign;
    string body;
    case ($urandom_range(0, 3))
      0: sign = "-";
      1: sign = "+";
      default: sign = "";
    endcase
    // magnitudes around 2^16 and 2^26 exercise both wraps
    case ($urandom_range(0, 3))
      0: body = $sformatf("%0d", $urandom_range(0, 99));
      1: body = $sformatf("%0d", $urandom_range(0, 70000));
      2: body = $sformatf("%0d", $urandom_range(0, 999999999));
      default: body = $sformatf("%0d", $urandom_range(60000000, 70000000));
    endcase
    case ($urandom_range(0, 11))
      0: body = {body, "x7"};
      1: body = {"q", body};
      2: body = "";
      default: ;
    endcase
    return {sign, body};
  endfunction

  function automatic string mem_token();
    case ($urandom_range(0, 11))
      0: return {imm_token(), reg_token(), ")"};
      1: return {imm_token(), "(", reg_token()};
      2: return {imm_token(), "(", reg_token(), ")zz"};
      default: return {imm_token(), "(", reg_token(), ")"};
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  // one line: mostly an instruction with random operands, sometimes noise
  task automatic random_line();
    string tok[$];
    int    m;
    int    kind;
    int    ending;
    logic  eof;
    line_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(0, 255)));
      line_bytes.push_back(8'd10);
    end else if (kind < 16) begin
      push_text(($urandom_range(0, 1) == 1) ? "\n" : "   \n");
    end else begin
      m = $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) begin
        tok.push_back(bad_names[$urandom_range(0, 9)]);
        m = 0;
      end else begin
        tok.push_back(mnem_names[m]);
      end
      if (m <= 4) begin
        repeat (3) tok.push_back(reg_token());
      end else if (m <= 6) begin
        tok.push_back(reg_token());
        tok.push_back(mem_token());
      end else if (m == 7) begin
        tok.push_back(reg_token());
        tok.push_back(reg_token());
        tok.push_back(imm_token());
      end else begin
        tok.push_back(imm_token());
      end
      if ($urandom_range(0, 15) == 0) void'(tok.pop_back());
      else if ($urandom_range(0, 15) == 0) repeat ($urandom_range(1, 3)) tok.push_back(reg_token());
      if ($urandom_range(0, 9) == 0) push_text("  ");
      foreach (tok[i]) begin
        if (i > 0) push_text(($urandom_range(0, 5) == 0) ? "   " : " ");
        push_text(tok[i]);
      end
      if ($urandom_range(0, 9) == 0) push_text(" ");
      line_bytes.push_back(8'd10);
    end
    // now and then end of file inside the stream: on the newline, on the
    // last text byte with no newline, or on a trailing space
    eof = 1'b0;
    if ($urandom_range(0, 11) == 0) begin
      eof    = 1'b1;
      ending = $urandom_range(0, 2);
      if (ending == 1 && line_bytes.size() > 1) void'(line_bytes.pop_back());
      else if (ending == 2) line_bytes[line_bytes.size() - 1] = 8'd32;
    end
    foreach (line_bytes[i]) send_byte(line_bytes[i], eof && (i == line_bytes.size() - 1));
  endtask

  initial begin : sink
    int pause;
    @(negedge rst);
    forever begin
      draw_pause(recv_calm, pause);
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // good lines first, while the write flag can still be high
    send_text("add $31, $0, $15\n", 1'b0);
    send_text("sub $1 $2 $3\n", 1'b0);
    send_text("and $10, $20, $30\n", 1'b0);
    send_text("  or   $4 $5 $6  \n", 1'b0);
    send_text("slt $7 $8 $9\n", 1'b0);
    send_text("lw $2, -32768($29)\n", 1'b0);
    send_text("sw $31 65535($0,)tail\n", 1'b0);
    send_text("lw $3 ($4)\n", 1'b0);
    send_text("beq $1 $2 -1\n", 1'b0);
    send_text("beq $5 $6\n", 1'b0);
    send_text("j 67108863\n", 1'b0);
    send_text("j -67108864\n", 1'b0);
    send_text("j\n", 1'b0);
    send_text("j 99999999", 1'b1);
    send_text("sw $1 +8($2)\n", 1'b1);
    // error lines
    send_text("add $1 $2 $3 $4\n", 1'b0);
    send_text("a b c d e f g h i\n", 1'b0);
    send_text("\n", 1'b0);
    send_text("mul $1 $2 $3\n", 1'b0);
    send_text("add $32 $1 $2\n", 1'b0);
    send_text("sub $05 $1 $2\n", 1'b0);
    send_text("or $1,x $2 $3\n", 1'b0);
    send_text("lw $1 4$2\n", 1'b0);
    send_text("sw $1 4($2\n", 1'b0);
    send_text("add $1 $2\n", 1'b0);
    // nul byte padding a short mnemonic
    send_text("or", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text(" $1 $2 $3\n", 1'b0);
    send_text("beq $1 $2 7 ", 1'b1);
    send_text(" ", 1'b1);
    send_text("x", 1'b1);

    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) random_line();

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    // room for any stray word still in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
